[rtl/core/rbbu_pkg.sv]
// Shared types and constants for the record byte buffer unpacker.
// Holds field widths, command codes, sequencer states and the result record.
// No dependencies.
package rbbu_pkg;

  localparam int CAPACITY_DEF = 1024;

  // Payload field widths
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 8;
  localparam int ADDR_IN_W = 11;
  localparam int COUNT_W   = 11;
  localparam int VALUE_W   = 32;

  // Headroom for the read cursor past the end of the store: up to 255 fields
  // of up to 255 bytes each, plus the length bytes.
  localparam int CURSOR_SPAN = 65536;

  // Longest field that unpacks into a value
  localparam int MAX_FIELD_BYTES = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 3'd0,
    FN_APPEND = 3'd1,
    FN_FETCH  = 3'd2,
    FN_SPACE  = 3'd3,
    FN_SETPTR = 3'd4,
    FN_READ   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RDWAIT,
    ST_FCNT,
    ST_FLEN,
    ST_FDATA,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] value;
    logic               bad_length;
    logic               record_end;
    logic               drain_done;
    logic               space_ok;
  } result_t;

endpackage

[rtl/core/rbbu_if.sv]
// Valid/ready channel interfaces for the record byte buffer unpacker.
// Command channel and result channel; widths come from rbbu_pkg.
interface rbbu_in_if import rbbu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [DATA_W-1:0]    data_byte;
  logic [ADDR_IN_W-1:0] address;
  logic [COUNT_W-1:0]   byte_count;

  modport source (output valid, func, data_byte, address, byte_count, input ready);
  modport sink   (input valid, func, data_byte, address, byte_count, output ready);
endinterface

interface rbbu_out_if import rbbu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [VALUE_W-1:0] value;
  logic               bad_length;
  logic               record_end;
  logic               drain_done;
  logic               space_ok;

  modport source (output valid, accepted, value, bad_length, record_end, drain_done,
                  space_ok, input ready);
  modport sink   (input valid, accepted, value, bad_length, record_end, drain_done,
                  space_ok, output ready);
endinterface

[rtl/core/record_byte_buffer_unpacker.sv]
// Record byte buffer unpacker: byte store with append pointer and field fetch.
// Depends on rbbu_pkg and the channel interfaces in rbbu_if.sv.
//
// The block holds CAPACITY bytes in one single-port memory with a registered
// read, and takes one command at a time. Append and space query pass their
// result through the result register and then the output register, whose
// load waits until it is free; read byte passes the memory read register
// first. Fetch next field reads the record's count byte, its length byte and
// then each data byte through the memory port, one byte a cycle, for a field
// of 1 to 4 data bytes (none for a bad length), and skips each empty record
// on the way. After reset and after each clear command the block sweeps zeros
// through every byte of the memory, one byte a cycle, with ready low.
// A finished result waits in an output register, so the next command can be
// taken while the previous result has not yet been transferred.
module record_byte_buffer_unpacker import rbbu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rbbu_in_if.sink   in_ch,
  rbbu_out_if.source out_ch
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int CUR_W  = $clog2(CAPACITY + CURSOR_SPAN);

  localparam logic [CUR_W-1:0]  CAP_CUR  = CUR_W'(CAPACITY);
  localparam logic [PTR_W-1:0]  CAP_PTR  = PTR_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CAPACITY - 1);

  // Sequencer and pointer state
  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [CUR_W-1:0]    rs_r, rs_nxt;
  logic [CUR_W-1:0]    fa_r, fa_nxt;
  logic [7:0]          fi_r, fi_nxt;
  logic                inrec_r, inrec_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;

  // Per-fetch working registers
  logic [7:0]          cnt_r, cnt_nxt;
  logic [7:0]          len_r, len_nxt;
  logic                last_r, last_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  result_t             res_r, res_nxt;

  // Memory port
  logic [DATA_W-1:0]   mem [CAPACITY];
  logic [DATA_W-1:0]   mem_q_r;
  logic                rd_oob_r;
  logic                mem_we;
  logic [DATA_W-1:0]   mem_wd;
  logic [ADDR_W-1:0]   wr_idx;
  logic [ADDR_W-1:0]   mem_idx;
  logic [CUR_W-1:0]    rd_addr;
  logic [DATA_W-1:0]   byte_q;

  // Output register
  logic                out_valid_r;
  result_t             out_res_r;
  logic                out_free;
  logic                out_load;

  // Helpers
  logic [CUR_W-1:0]    wp_ext;
  logic [CUR_W-1:0]    addr_ext;
  logic [CUR_W-1:0]    rs_inc;
  logic [CUR_W-1:0]    fa_fin;
  logic [VALUE_W-1:0]  val_step;
  logic                fin;
  logic [7:0]          fin_len;
  logic                fin_last;
  logic                fin_bad;
  logic [VALUE_W-1:0]  fin_val;

  assign wp_ext   = CUR_W'(wp_r);
  assign addr_ext = CUR_W'(in_ch.address);
  assign byte_q   = rd_oob_r ? '0 : mem_q_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_PUSH) && out_free;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign mem_idx  = mem_we ? wr_idx : rd_addr[ADDR_W-1:0];

  // Next state, memory requests and result
  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rs_nxt    = rs_r;
    fa_nxt    = fa_r;
    fi_nxt    = fi_r;
    inrec_nxt = inrec_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    k_nxt     = k_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_wd    = '0;
    wr_idx    = '0;
    rd_addr   = '0;
    rs_inc    = rs_r + CUR_W'(1);
    val_step  = {val_r[VALUE_W-DATA_W-1:0], byte_q};
    fin       = 1'b0;
    fin_len   = len_r;
    fin_last  = last_r;
    fin_bad   = 1'b0;
    fin_val   = '0;
    fa_fin    = '0;

    case (state_r)
      // Sweep zeros through the store
      ST_CLR: begin
        mem_we  = 1'b1;
        wr_idx  = clr_r;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take a command and dispatch
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          case (in_ch.func)
            FN_CLEAR: begin
              wp_nxt    = '0;
              rs_nxt    = '0;
              fa_nxt    = '0;
              fi_nxt    = '0;
              inrec_nxt = 1'b0;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            FN_APPEND: begin
              if (wp_r < CAP_PTR) begin
                mem_we           = 1'b1;
                wr_idx           = wp_r[ADDR_W-1:0];
                mem_wd           = in_ch.data_byte;
                wp_nxt           = wp_r + PTR_W'(1);
                res_nxt.accepted = 1'b1;
              end
              state_nxt = ST_PUSH;
            end
            FN_FETCH: begin
              if (!inrec_r && rs_r >= wp_ext) begin
                res_nxt.drain_done = 1'b1;
                rs_nxt    = '0;
                fi_nxt    = '0;
                fa_nxt    = '0;
                state_nxt = ST_PUSH;
              end else begin
                rd_addr   = rs_r;
                state_nxt = ST_FCNT;
              end
            end
            FN_SPACE: begin
              res_nxt.space_ok = (wp_ext + CUR_W'(in_ch.byte_count)) < CAP_CUR;
              state_nxt        = ST_PUSH;
            end
            FN_SETPTR: begin
              wp_nxt = (addr_ext > CAP_CUR) ? CAP_PTR : PTR_W'(addr_ext);
            end
            FN_READ: begin
              rd_addr   = addr_ext;
              state_nxt = ST_RDWAIT;
            end
            default: ;
          endcase
        end
      end

      // Byte read returns
      ST_RDWAIT: begin
        res_nxt.value = VALUE_W'(byte_q);
        state_nxt     = ST_PUSH;
      end

      // Count byte: skip empty records, open a new record, continue one, or end the drain
      ST_FCNT: begin
        cnt_nxt = byte_q;
        if (!inrec_r) begin
          if (byte_q == '0) begin
            rs_nxt = rs_inc;
            if (rs_inc >= wp_ext) begin
              res_nxt.drain_done = 1'b1;
              rs_nxt    = '0;
              fi_nxt    = '0;
              fa_nxt    = '0;
              state_nxt = ST_PUSH;
            end else begin
              rd_addr = rs_inc;
            end
          end else begin
            inrec_nxt = 1'b1;
            fi_nxt    = '0;
            fa_nxt    = rs_inc + CUR_W'(byte_q);
            rd_addr   = rs_inc;
            state_nxt = ST_FLEN;
          end
        end else begin
          rd_addr   = rs_inc + CUR_W'(fi_r);
          state_nxt = ST_FLEN;
        end
      end

      // Length byte: start the data reads or flag a bad length
      ST_FLEN: begin
        len_nxt  = byte_q;
        last_nxt = (9'(fi_r) + 9'd1) >= 9'(cnt_r);
        if (byte_q >= 8'd1 && byte_q <= 8'(MAX_FIELD_BYTES)) begin
          rd_addr   = fa_r;
          k_nxt     = '0;
          val_nxt   = '0;
          state_nxt = ST_FDATA;
        end else begin
          fin      = 1'b1;
          fin_len  = byte_q;
          fin_last = last_nxt;
          fin_bad  = 1'b1;
        end
      end

      // Data bytes: shift in big-endian
      ST_FDATA: begin
        val_nxt = val_step;
        if ((8'(k_r) + 8'd1) < len_r) begin
          k_nxt   = k_r + 2'd1;
          rd_addr = fa_r + CUR_W'(k_r) + CUR_W'(1);
        end else begin
          fin     = 1'b1;
          fin_val = val_step;
        end
      end

      // Hand the result to the output register
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Close out a field: advance the cursor, end the record on its last field
    if (fin) begin
      fa_fin             = fa_r + CUR_W'(fin_len);
      fa_nxt             = fa_fin;
      fi_nxt             = fi_r + 8'd1;
      res_nxt.value      = fin_val;
      res_nxt.bad_length = fin_bad;
      res_nxt.record_end = fin_last;
      if (fin_last) begin
        rs_nxt    = fa_fin;
        inrec_nxt = 1'b0;
        fi_nxt    = '0;
      end
      state_nxt = ST_PUSH;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pointer and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rs_r    <= '0;
      fa_r    <= '0;
      fi_r    <= '0;
      inrec_r <= 1'b0;
      clr_r   <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rs_r    <= rs_nxt;
      fa_r    <= fa_nxt;
      fi_r    <= fi_nxt;
      inrec_r <= inrec_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    val_r  <= val_nxt;
    res_r  <= res_nxt;
  end

  // Byte store: single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wd;
    end else begin
      mem_q_r <= mem[mem_idx];
    end
    rd_oob_r <= (rd_addr >= CAP_CUR);
  end

  // Output register: load on push, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_res_r.accepted;
  assign out_ch.value      = out_res_r.value;
  assign out_ch.bad_length = out_res_r.bad_length;
  assign out_ch.record_end = out_res_r.record_end;
  assign out_ch.drain_done = out_res_r.drain_done;
  assign out_ch.space_ok   = out_res_r.space_ok;

endmodule

[rtl/core/rbbu_checker.sv]
// Port-level checks on the result channel of the record byte buffer unpacker.
// Depends on rbbu_pkg; bound to record_byte_buffer_unpacker below.
module rbbu_checker import rbbu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               accepted,
  input logic [VALUE_W-1:0] value,
  input logic               bad_length,
  input logic               record_end,
  input logic               drain_done,
  input logic               space_ok
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(record_end))
    else $error("result changed while stalled");

  // Drain done carries nothing else
  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drain_done |-> value == '0 && !bad_length && !record_end &&
                                !accepted && !space_ok)
    else $error("drain done result carries other fields");

  // Bad length gives a zero value and is a fetch result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_length |-> value == '0 && !accepted && !space_ok && !drain_done)
    else $error("bad length result with nonzero value");

  // Space query answers stand alone
  a_space_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && space_ok |-> value == '0 && !accepted && !bad_length &&
                              !record_end && !drain_done)
    else $error("space query result carries other fields");

endmodule

bind record_byte_buffer_unpacker rbbu_checker u_rbbu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .accepted   (out_ch.accepted),
  .value      (out_ch.value),
  .bad_length (out_ch.bad_length),
  .record_end (out_ch.record_end),
  .drain_done (out_ch.drain_done),
  .space_ok   (out_ch.space_ok)
);
